// ===== src/srrip_cache_replacement_unit_assert.svh =====
// assertion macros shared by the replacement unit modules
// no dependencies; the including module must have clk and rst_n in scope
`ifndef SRRIP_CACHE_REPLACEMENT_UNIT_ASSERT_SVH
`define SRRIP_CACHE_REPLACEMENT_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define SRRIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SRRIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/srrip_pkg.sv =====
// shared types and constants of the srrip replacement unit
// no dependencies
package srrip_pkg;

    // default geometry
    localparam int DEF_NUM_SETS = 2048;
    localparam int DEF_NUM_WAYS = 16;
    localparam int DEF_MAX_RRPV = 3;

    // stream payload widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    // operation codes
    typedef enum logic [1:0] {
        OP_VICTIM = 2'd0,
        OP_FILL   = 2'd1,
        OP_HIT    = 2'd2
    } op_t;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic clear_step;
        logic exec;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;
    } dp_sts_t;

endpackage

// ===== src/srrip_ctrl.sv =====
// controller state machine of the srrip replacement unit
// depends on srrip_pkg and srrip_cache_replacement_unit_assert.svh
`include "srrip_cache_replacement_unit_assert.svh"

module srrip_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output srrip_pkg::ctrl_cmd_t cmd,
    input  srrip_pkg::dp_sts_t   sts
);
    import srrip_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // output register must be free before the result lands
                if (!out_valid_reg || m_tready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    // checks
    `SRRIP_ASSERT(a_exec_out_free, cmd.exec |-> (!out_valid_reg || m_tready), "result overwrote a pending item")
    `SRRIP_ASSERT_NEXT(a_exec_shows, cmd.exec, m_tvalid, "result not presented after execute")
    `SRRIP_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready && state_reg == ST_EXEC, "item accepted while busy")
    `SRRIP_ASSERT_NEXT(a_clear_done, state_reg == ST_CLEAR && sts.clear_last, s_tready, "not ready after clearing pass")

endmodule

// ===== src/srrip_dpath.sv =====
// datapath of the srrip replacement unit: rrpv row memory, victim search, updates
// depends on srrip_pkg
module srrip_dpath #(
    parameter int NUM_SETS = srrip_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS = srrip_pkg::DEF_NUM_WAYS,
    parameter int MAX_RRPV = srrip_pkg::DEF_MAX_RRPV
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [srrip_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [srrip_pkg::S_TUSER_W-1:0] s_tuser,
    output logic [srrip_pkg::M_TDATA_W-1:0] m_tdata,
    input  srrip_pkg::ctrl_cmd_t            cmd,
    output srrip_pkg::dp_sts_t              sts
);
    import srrip_pkg::*;

    localparam int RW        = $clog2(MAX_RRPV + 1);
    localparam int ROW_W     = NUM_WAYS * RW;
    localparam int SET_AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int MASK_WAYS = (NUM_WAYS < 16) ? NUM_WAYS : 16;
    localparam logic [RW-1:0] RRPV_MAX  = RW'(MAX_RRPV);
    localparam logic [RW-1:0] RRPV_FILL = RW'(MAX_RRPV - 1);

    // item registers
    logic [1:0]  op_reg;
    logic [10:0] set_reg;
    logic [3:0]  way_reg;
    logic        wb_reg;
    logic [15:0] mask_reg;

    logic [ROW_W-1:0]  mem [NUM_SETS];
    logic [ROW_W-1:0]  row_reg;
    logic [SET_AW-1:0] rd_addr;
    logic [SET_AW-1:0] clr_cnt_reg;

    logic              set_ok;
    logic              way_ok;
    logic              inv_found;
    logic [3:0]        inv_way;
    logic [MAX_RRPV:0] present;
    logic [RW-1:0]     top;
    logic [3:0]        pick;
    logic [RW-1:0]     rounds;
    logic [RW:0]       rounds_ext;
    logic [ROW_W-1:0]  aged_row;
    logic [ROW_W-1:0]  upd_row;
    logic [RW-1:0]     upd_val;
    logic              upd_we;
    logic [3:0]        res_way;
    logic              res_inv;
    logic [1:0]        res_rounds;

    logic              mem_we;
    logic [SET_AW-1:0] mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic [7:0]        out_data_reg;

    // capture item fields on accept
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= s_tuser[1:0];
            wb_reg   <= s_tuser[2];
            set_reg  <= s_tdata[10:0];
            way_reg  <= s_tdata[14:11];
            mask_reg <= s_tdata[30:15];
        end
    end

    assign rd_addr = SET_AW'(32'(s_tdata[10:0]));

    // clearing pass row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + SET_AW'(1);
        end
    end

    assign sts.clear_last = (clr_cnt_reg == SET_AW'(NUM_SETS - 1));

    // row memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.load_item)
        begin
            row_reg <= mem[rd_addr];
        end
    end

    assign set_ok = (32'(set_reg) < 32'(NUM_SETS));
    assign way_ok = (32'(way_reg) < 32'(NUM_WAYS));

    // lowest invalid way; ways beyond the mask count as valid
    always_comb
    begin
        inv_found = 1'b0;
        inv_way   = 4'd0;
        for (int w = MASK_WAYS - 1; w >= 0; w--)
        begin
            if (!mask_reg[w])
            begin
                inv_found = 1'b1;
                inv_way   = 4'(w);
            end
        end
    end

    // which rrpv levels occur in the row
    always_comb
    begin
        present = '0;
        for (int v = 0; v <= MAX_RRPV; v++)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (row_reg[w*RW +: RW] == RW'(v))
                begin
                    present[v] = 1'b1;
                end
            end
        end
    end

    // highest level present
    always_comb
    begin
        top = '0;
        for (int v = 0; v <= MAX_RRPV; v++)
        begin
            if (present[v])
            begin
                top = RW'(v);
            end
        end
    end

    // first way at the highest level
    always_comb
    begin
        pick = 4'd0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (row_reg[w*RW +: RW] == top)
            begin
                pick = 4'(w);
            end
        end
    end

    assign rounds     = RRPV_MAX - top;
    assign rounds_ext = {1'b0, rounds};

    // aged row, saturating at the maximum
    always_comb
    begin
        logic [RW:0] sum;
        aged_row = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            sum = {1'b0, row_reg[w*RW +: RW]} + rounds_ext;
            aged_row[w*RW +: RW] = (sum > {1'b0, RRPV_MAX}) ? RRPV_MAX : sum[RW-1:0];
        end
    end

    // per-operation update and result
    always_comb
    begin
        upd_we     = 1'b0;
        upd_val    = RRPV_FILL;
        res_way    = 4'd0;
        res_inv    = 1'b0;
        res_rounds = 2'd0;
        case (op_reg)
            OP_VICTIM:
            begin
                if (inv_found)
                begin
                    res_way = inv_way;
                    res_inv = 1'b1;
                end
                else if (set_ok)
                begin
                    upd_we     = 1'b1;
                    res_way    = pick;
                    res_rounds = (rounds_ext > (RW+1)'(3)) ? 2'd3 : rounds_ext[1:0];
                end
            end
            OP_FILL:
            begin
                upd_we  = set_ok && way_ok;
                upd_val = wb_reg ? RRPV_MAX : RRPV_FILL;
            end
            OP_HIT:
            begin
                upd_we  = set_ok && way_ok && !wb_reg;
                upd_val = '0;
            end
            default:
            begin
                upd_we = 1'b0;
            end
        endcase
    end

    // row with the addressed way replaced
    always_comb
    begin
        upd_row = row_reg;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (32'(w) == 32'(way_reg))
            begin
                upd_row[w*RW +: RW] = upd_val;
            end
        end
    end

    // write port: clearing pass or read-modify-write
    always_comb
    begin
        if (cmd.clear_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = {NUM_WAYS{RRPV_MAX}};
        end
        else
        begin
            mem_we    = cmd.exec && upd_we;
            mem_waddr = SET_AW'(32'(set_reg));
            mem_wdata = (op_reg == OP_VICTIM) ? aged_row : upd_row;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_data_reg <= {1'b0, res_rounds, res_inv, res_way};
        end
    end

    assign m_tdata = out_data_reg;

endmodule

// ===== src/srrip_cache_replacement_unit.sv =====
// srrip replacement unit: set row read at the accepting edge, updated, written back
// and the result registered at the execute edge
// no new item is accepted until the single row read-modify-write has executed; the execute edge
// waits while an earlier result is still held on the output
// after reset a clearing pass over all NUM_SETS rows (2048 by default) sets every
// entry to the maximum rrpv; no item is accepted during it
module srrip_cache_replacement_unit #(
    parameter int NUM_SETS = srrip_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS = srrip_pkg::DEF_NUM_WAYS,
    parameter int MAX_RRPV = srrip_pkg::DEF_MAX_RRPV
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // set_index[10:0], way_index[14:11], way_valid_mask[30:15], zero [31]
    input  logic [srrip_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0], is_writeback[2]
    input  logic [srrip_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // victim_way[3:0], took_invalid_way[4], age_count[6:5], zero [7]
    output logic [srrip_pkg::M_TDATA_W-1:0] m_tdata
);
    import srrip_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // control
    srrip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath
    srrip_dpath #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS),
        .MAX_RRPV (MAX_RRPV)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
